@@ rtl/pmr_pkg.sv @@
// Shared types and constants for the polynomial multiply-reduce block.
// Used by pmr_cell, polynomial_multiply_reduce_top and the testbench.
// No dependencies.
package pmr_pkg;

	localparam int unsigned MAX_DEGREE = 15;
	localparam int unsigned COEF_W     = 32;
	localparam int unsigned PCOEF_W    = 64;
	localparam int unsigned PDEG_W     = 5;

	localparam logic signed [PCOEF_W-1:0] SAT_MAX = {1'b0, {(PCOEF_W-1){1'b1}}};
	localparam logic signed [PCOEF_W-1:0] SAT_MIN = {1'b1, {(PCOEF_W-1){1'b0}}};

	typedef struct packed {
		logic                     operand_select;
		logic signed [COEF_W-1:0] coefficient;
		logic                     last_coefficient_in;
	} coef_word_t;

	typedef struct packed {
		logic signed [PCOEF_W-1:0] product_coefficient;
		logic [PDEG_W-1:0]         product_degree;
		logic                      last_coefficient_out;
		logic                      overflow_flag;
	} prod_word_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} pmr_state_t;

	// common controls broadcast to every cell of the chain
	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} cell_ctrl_t;

endpackage

@@ rtl/pmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the operand B store and the product buffer.
// No package dependencies.
module pmr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pmr_cell.sv @@
// One cell of the transposed convolution chain: holds one A coefficient,
// multiplies it by the broadcast B value and adds into the neighbor's sum.
// Depends on pmr_pkg.
module pmr_cell #(
	parameter int unsigned ACC_W = 68
) (
	input  logic                                  clk,
	input  pmr_pkg::cell_ctrl_t                   ctrl,
	input  logic                                  load,
	input  logic                                  active,
	input  logic signed [pmr_pkg::COEF_W-1:0]     coef_in,
	input  logic signed [pmr_pkg::COEF_W-1:0]     x,
	input  logic signed [ACC_W-1:0]               acc_in,
	output logic signed [ACC_W-1:0]               acc_out
);

	logic signed [pmr_pkg::COEF_W-1:0]  a_q;
	logic signed [pmr_pkg::PCOEF_W-1:0] prod;
	logic signed [pmr_pkg::PCOEF_W-1:0] m_s2;
	logic signed [ACC_W-1:0]            acc_q;

	assign prod = a_q * x;

	always_ff @(posedge clk) begin
		if (load) begin
			a_q <= coef_in;
		end
		// cells past the loaded count stand in for zero coefficients
		if (ctrl.mul_en) begin
			m_s2 <= active ? prod : '0;
		end
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= ACC_W'(m_s2) + acc_in;
		end
	end

	assign acc_out = acc_q;

endmodule

@@ rtl/polynomial_multiply_reduce_top.sv @@
// Polynomial multiplier with saturation and trailing-zero trim: top level.
// Depends on pmr_pkg, pmr_ram, pmr_cell.
//
//  port   dir  type         handshake           carries
//  coef   in   coef_word_t  coef_valid/coef_stall   one operand coefficient
//  prod   out  prod_word_t  prod_valid/prod_stall   one product coefficient
//
// A coefficient word is taken when coef_valid is high and coef_stall is low.
// The last word of B starts the product: the cell chain steps through degrees
// 0 to dA+dB, one multiplier per cell, then drains. Results then leave one word
// at a time; a buffer read waits while one is pending or a held word is stalled.
// Input stalls during the product pass, and a starting word stalls while results
// still leave. arst_n clears state, input counts and flags and handshake, not the stores.
module polynomial_multiply_reduce_top #(
	parameter int unsigned MAX_DEGREE = pmr_pkg::MAX_DEGREE
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                coef_valid,
	output logic                coef_stall,
	input  pmr_pkg::coef_word_t coef,
	output logic                prod_valid,
	input  logic                prod_stall,
	output pmr_pkg::prod_word_t prod
);

	localparam int unsigned STORE_DEPTH = MAX_DEGREE + 1;
	localparam int unsigned PROD_DEPTH  = 2 * MAX_DEGREE + 1;
	localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int unsigned BAW         = $clog2(STORE_DEPTH);
	localparam int unsigned DEG_W       = $clog2(PROD_DEPTH);
	localparam int unsigned ACC_W       = pmr_pkg::PCOEF_W + $clog2(STORE_DEPTH);
	localparam int unsigned CW          = pmr_pkg::COEF_W;
	localparam int unsigned PW          = pmr_pkg::PCOEF_W;
	localparam int unsigned PDW         = pmr_pkg::PDEG_W;

	pmr_pkg::pmr_state_t state_q, state_d;

	logic [CNT_W-1:0] a_cnt_q, b_cnt_q, na_q, nb_q, nb_next;
	logic             a_done_q, dropped_q;
	logic [DEG_W-1:0] deg_full_q, t_q, w_q, deg_q, k_q;
	logic             ovf_q;
	logic             v_s1, v_s2, v_s3, inb_s1;
	logic             rd_pend_q, rd_last_q;
	pmr_pkg::prod_word_t prod_q;
	logic             prod_valid_q;

	logic accept, a_full, b_full, a_wr, a_drop, b_wr, b_drop, fire;
	logic run_issue, rd_issue;

	logic [CW-1:0]          b_rdata;
	logic signed [CW-1:0]   bcast_x;
	logic [PW-1:0]          res_rdata;
	logic signed [ACC_W-1:0] acc [STORE_DEPTH+1];
	logic signed [ACC_W-1:0] y;
	logic                   y_ovr;
	logic signed [PW-1:0]   y_sat;
	pmr_pkg::cell_ctrl_t    cell_ctrl;

	// ---------------- input side ----------------
	assign accept = coef_valid & ~coef_stall;
	assign a_full = (a_cnt_q == CNT_W'(STORE_DEPTH));
	assign b_full = (b_cnt_q == CNT_W'(STORE_DEPTH));
	assign a_wr   = accept & ~coef.operand_select & ~a_done_q & ~a_full;
	assign a_drop = accept & ~coef.operand_select & ~a_done_q & a_full;
	assign b_wr   = accept & coef.operand_select & ~b_full;
	assign b_drop = accept & coef.operand_select & b_full;
	assign fire   = accept & coef.operand_select & coef.last_coefficient_in;
	assign nb_next = b_full ? b_cnt_q : b_cnt_q + CNT_W'(1);

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			pmr_pkg::ST_LOAD: begin
				if (fire) state_d = pmr_pkg::ST_RUN;
			end
			pmr_pkg::ST_RUN: begin
				if (t_q == deg_full_q) state_d = pmr_pkg::ST_DRAIN;
			end
			pmr_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) state_d = pmr_pkg::ST_EMIT;
			end
			pmr_pkg::ST_EMIT: begin
				if (rd_issue && k_q == deg_q) state_d = pmr_pkg::ST_LOAD;
			end
			default: state_d = pmr_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		coef_stall = 1'b1;
		run_issue  = 1'b0;
		rd_issue   = 1'b0;
		case (state_q)
			pmr_pkg::ST_LOAD: begin
				coef_stall = 1'b0;
			end
			pmr_pkg::ST_RUN: begin
				run_issue = 1'b1;
			end
			pmr_pkg::ST_DRAIN: begin
				coef_stall = 1'b1;
			end
			pmr_pkg::ST_EMIT: begin
				// loading goes on; only a word that starts a product waits
				coef_stall = coef_valid & coef.operand_select & coef.last_coefficient_in;
				rd_issue   = ~rd_pend_q & (~prod_valid_q | ~prod_stall);
			end
			default: coef_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pmr_pkg::ST_LOAD;
			a_cnt_q   <= '0;
			b_cnt_q   <= '0;
			a_done_q  <= 1'b0;
			dropped_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			rd_pend_q <= 1'b0;
			prod_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= run_issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			rd_pend_q <= rd_issue;
			if (fire) begin
				a_cnt_q   <= '0;
				b_cnt_q   <= '0;
				a_done_q  <= 1'b0;
				dropped_q <= 1'b0;
			end else begin
				if (a_wr) a_cnt_q <= a_cnt_q + CNT_W'(1);
				if (b_wr) b_cnt_q <= b_cnt_q + CNT_W'(1);
				if (accept && !coef.operand_select && coef.last_coefficient_in) begin
					a_done_q <= 1'b1;
				end
				if (a_drop || b_drop) dropped_q <= 1'b1;
			end
			if (rd_pend_q) begin
				prod_valid_q <= 1'b1;
			end else if (!prod_stall) begin
				prod_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- product bookkeeping ----------------
	always_ff @(posedge clk) begin
		if (fire) begin
			na_q       <= a_cnt_q;
			nb_q       <= nb_next;
			deg_full_q <= (a_cnt_q == '0) ? '0
				: DEG_W'(a_cnt_q) + DEG_W'(nb_next) - DEG_W'(2);
			ovf_q      <= dropped_q | b_full;
			deg_q      <= '0;
			t_q        <= '0;
			w_q        <= '0;
			k_q        <= '0;
		end else begin
			if (run_issue) t_q <= t_q + DEG_W'(1);
			if (v_s3) begin
				w_q <= w_q + DEG_W'(1);
				if (y_sat != '0) deg_q <= w_q;
				if (y_ovr) ovf_q <= 1'b1;
			end
			if (rd_issue) k_q <= k_q + DEG_W'(1);
		end
		inb_s1 <= DEG_W'(nb_q) > t_q;
		if (rd_issue) rd_last_q <= (k_q == deg_q);
		if (rd_pend_q) begin
			prod_q.product_coefficient  <= $signed(res_rdata);
			prod_q.product_degree       <= PDW'(deg_q);
			prod_q.last_coefficient_out <= rd_last_q;
			prod_q.overflow_flag        <= ovf_q;
		end
	end

	// ---------------- operand B store ----------------
	pmr_ram #(
		.WIDTH (CW),
		.DEPTH (STORE_DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (b_wr),
		.waddr (b_cnt_q[BAW-1:0]),
		.wdata (coef.coefficient),
		.raddr (t_q[BAW-1:0]),
		.rdata (b_rdata)
	);

	// B values past the stored count feed zeros to flush the chain
	assign bcast_x = inb_s1 ? $signed(b_rdata) : '0;

	// ---------------- cell chain ----------------
	assign cell_ctrl.clr    = fire;
	assign cell_ctrl.mul_en = v_s1;
	assign cell_ctrl.acc_en = v_s2;
	assign acc[STORE_DEPTH] = '0;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		pmr_cell #(
			.ACC_W (ACC_W)
		) u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl),
			.load    (a_wr && a_cnt_q == CNT_W'(i)),
			.active  (CNT_W'(i) < na_q),
			.coef_in (coef.coefficient),
			.x       (bcast_x),
			.acc_in  (acc[i+1]),
			.acc_out (acc[i])
		);
	end

	// ---------------- saturate and buffer ----------------
	assign y     = acc[0];
	assign y_ovr = (|y[ACC_W-1:PW-1]) & ~(&y[ACC_W-1:PW-1]);
	assign y_sat = y_ovr ? (y[ACC_W-1] ? pmr_pkg::SAT_MIN : pmr_pkg::SAT_MAX)
		: y[PW-1:0];

	pmr_ram #(
		.WIDTH (PW),
		.DEPTH (PROD_DEPTH)
	) u_res_buf (
		.clk   (clk),
		.we    (v_s3),
		.waddr (w_q),
		.wdata (y_sat),
		.raddr (k_q),
		.rdata (res_rdata)
	);

	assign prod_valid = prod_valid_q;
	assign prod       = prod_q;

	// ---------------- checks ----------------
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !prod_valid_q)
		else $error("result word loaded over a pending word");

	a_pipe_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == pmr_pkg::ST_RUN || state_q == pmr_pkg::ST_DRAIN))
		else $error("chain result outside product pass");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (k_q <= deg_q))
		else $error("buffer read past product degree");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (w_q <= deg_full_q))
		else $error("buffer write past full degree");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for polynomial_multiply_reduce_top: random and directed coefficient words,
// a scoreboard of expected product words from a behavioral convolution model.
// Depends on pmr_pkg and the block's RTL.
module testbench;

	localparam bit SEL_A = 1'b0;
	localparam bit SEL_B = 1'b1;
	localparam int STORE_DEPTH = pmr_pkg::MAX_DEGREE + 1;
	localparam int PROD_DEPTH = 2 * pmr_pkg::MAX_DEGREE + 1;
	localparam int TOTAL_WORDS = 160;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic coef_valid = 1'b0;
	logic coef_stall;
	pmr_pkg::coef_word_t coef = '0;
	logic prod_valid;
	logic prod_stall = 1'b0;
	pmr_pkg::prod_word_t prod;

	polynomial_multiply_reduce_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef_valid (coef_valid),
		.coef_stall (coef_stall),
		.coef       (coef),
		.prod_valid (prod_valid),
		.prod_stall (prod_stall),
		.prod       (prod)
	);

	always #5 clk = ~clk;

	// behavioral copy of the operand stores
	logic signed [pmr_pkg::COEF_W-1:0] a_coefs [STORE_DEPTH];
	logic signed [pmr_pkg::COEF_W-1:0] b_coefs [STORE_DEPTH];
	int a_count = 0;
	int b_count = 0;
	bit a_closed = 1'b0;
	bit coefs_dropped = 1'b0;

	pmr_pkg::coef_word_t pending_words [$];
	pmr_pkg::prod_word_t expected_terms [$];

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int products = 0;
	int saturated_products = 0;
	int dropped_products = 0;
	int top_degree = 0;

	// full convolution, saturation and trailing-zero trim of the loaded pair
	task automatic multiply_and_trim();
		logic signed [71:0] acc;
		logic signed [71:0] pa;
		logic signed [71:0] pb;
		logic signed [pmr_pkg::PCOEF_W-1:0] terms [PROD_DEPTH];
		int deg;
		bit ovf;
		bit sat;
		pmr_pkg::prod_word_t r;
		ovf = coefs_dropped;
		sat = 1'b0;
		deg = 0;
		foreach (terms[k]) terms[k] = '0;
		if (a_count > 0 && b_count > 0) begin
			deg = a_count + b_count - 2;
			for (int k = 0; k <= deg; k++) begin
				acc = '0;
				for (int i = 0; i < a_count; i++) begin
					if (k >= i && k - i < b_count) begin
						pa = a_coefs[i];
						pb = b_coefs[k-i];
						acc += pa * pb;
					end
				end
				if (acc > pmr_pkg::SAT_MAX) begin
					terms[k] = pmr_pkg::SAT_MAX;
					sat = 1'b1;
				end else if (acc < pmr_pkg::SAT_MIN) begin
					terms[k] = pmr_pkg::SAT_MIN;
					sat = 1'b1;
				end else begin
					terms[k] = acc[pmr_pkg::PCOEF_W-1:0];
				end
			end
		end
		ovf |= sat;
		while (deg > 0 && terms[deg] == 0) deg--;
		for (int k = 0; k <= deg; k++) begin
			r.product_coefficient = terms[k];
			r.product_degree = deg[pmr_pkg::PDEG_W-1:0];
			r.last_coefficient_out = (k == deg);
			r.overflow_flag = ovf;
			expected_terms.push_back(r);
		end
		products++;
		if (sat) saturated_products++;
		if (coefs_dropped) dropped_products++;
		if (deg > top_degree) top_degree = deg;
		a_count = 0;
		b_count = 0;
		a_closed = 1'b0;
		coefs_dropped = 1'b0;
	endtask

	task automatic absorb_word(pmr_pkg::coef_word_t w);
		if (w.operand_select == SEL_A) begin
			if (!a_closed) begin
				if (a_count < STORE_DEPTH) begin
					a_coefs[a_count] = w.coefficient;
					a_count++;
				end else begin
					coefs_dropped = 1'b1;
				end
				if (w.last_coefficient_in) a_closed = 1'b1;
			end
		end else begin
			if (b_count < STORE_DEPTH) begin
				b_coefs[b_count] = w.coefficient;
				b_count++;
			end else begin
				coefs_dropped = 1'b1;
			end
			if (w.last_coefficient_in) multiply_and_trim();
		end
	endtask

	task automatic compare_result(pmr_pkg::prod_word_t got);
		pmr_pkg::prod_word_t want;
		if (expected_terms.size() == 0) begin
			$error("product word with nothing expected: %h", got);
			errors++;
		end else begin
			want = expected_terms.pop_front();
			if (got.product_coefficient !== want.product_coefficient) begin
				$error("product_coefficient: expected %h, got %h",
					want.product_coefficient, got.product_coefficient);
				errors++;
			end
			if (got.product_degree !== want.product_degree) begin
				$error("product_degree: expected %0d, got %0d",
					want.product_degree, got.product_degree);
				errors++;
			end
			if (got.last_coefficient_out !== want.last_coefficient_out) begin
				$error("last_coefficient_out: expected %b, got %b",
					want.last_coefficient_out, got.last_coefficient_out);
				errors++;
			end
			if (got.overflow_flag !== want.overflow_flag) begin
				$error("overflow_flag: expected %b, got %b",
					want.overflow_flag, got.overflow_flag);
				errors++;
			end
		end
	endtask

	function automatic logic signed [pmr_pkg::COEF_W-1:0] rand_coef();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20) return '0;
		if (r < 35) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return 32'sh0001_0000;
				3: return -32'sd1;
				default: return 32'sh0000_0001;
			endcase
		end
		if (r < 50) return $signed(32'($urandom_range(0, 32'h3_FFFF))) - 32'sh2_0000;
		return $signed($urandom());
	endfunction

	// mostly short operands, some mid-size, a few past the store depth
	function automatic int pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 4);
		if (r < 92) return $urandom_range(5, 12);
		if (r < 97) return $urandom_range(13, 16);
		return $urandom_range(17, 19);
	endfunction

	function automatic int pick_idle(bit burst);
		int unsigned r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic push_word(bit sel, logic signed [pmr_pkg::COEF_W-1:0] value, bit last);
		pmr_pkg::coef_word_t w;
		w.operand_select = sel;
		w.coefficient = value;
		w.last_coefficient_in = last;
		pending_words.push_back(w);
	endtask

	task automatic push_operand(bit sel, int n, bit close);
		for (int i = 0; i < n; i++) push_word(sel, rand_coef(), close && i == n - 1);
	endtask

	// sender
	int send_idle = 0;
	bit send_burst = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid <= 1'b0;
		end else begin
			if (coef_valid && !coef_stall) begin
				absorb_word(coef);
				words_sent++;
				if (words_sent % 20 == 0) send_burst = ($urandom_range(0, 3) == 0);
			end
			if (!coef_valid || !coef_stall) begin
				if (send_idle > 0) begin
					send_idle--;
					coef_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					coef <= pending_words.pop_front();
					coef_valid <= 1'b1;
					send_idle = pick_idle(send_burst);
				end else begin
					coef_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks words, drives stall in stretches, one long hold-off
	int stall_left = 0;
	int open_left = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_stall <= 1'b0;
		end else begin
			if (prod_valid && !prod_stall) begin
				compare_result(prod);
				results_seen++;
			end
			if (results_seen >= 40 && !long_hold_done) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD;
				open_left = 0;
			end
			if (stall_left == 0 && open_left == 0) begin
				stall_left = pick_idle($urandom_range(0, 5) == 0);
				open_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				stall_left--;
				prod_stall <= 1'b1;
			end else begin
				open_left--;
				prod_stall <= 1'b0;
			end
		end
	end

	initial begin
		// empty A: B alone gives a single zero word
		push_word(SEL_B, 32'sh0001_0000, 1'b1);
		// most negative coefficients, positive saturation at degree 1
		push_word(SEL_A, 32'sh8000_0000, 1'b0);
		push_word(SEL_A, 32'sh8000_0000, 1'b1);
		push_word(SEL_B, 32'sh8000_0000, 1'b0);
		push_word(SEL_B, 32'sh8000_0000, 1'b1);
		// extremes against each other, negative saturation at degree 2
		repeat (2) push_word(SEL_A, 32'sh8000_0000, 1'b0);
		push_word(SEL_A, 32'sh8000_0000, 1'b1);
		repeat (2) push_word(SEL_B, 32'sh7FFF_FFFF, 1'b0);
		push_word(SEL_B, 32'sh7FFF_FFFF, 1'b1);
		// B before A closes, A after A closed is ignored, trailing zero trimmed
		push_word(SEL_B, 32'sh0001_0000, 1'b0);
		push_word(SEL_A, 32'sh0000_0001, 1'b1);
		push_word(SEL_A, 32'sh7FFF_FFFF, 1'b1);
		push_word(SEL_B, 32'sh0000_0000, 1'b1);
		// all-zero product
		push_word(SEL_A, 32'sh0000_0000, 1'b1);
		push_word(SEL_B, 32'sh0000_0000, 1'b1);

		// one full-size pair reaching the top degree
		push_operand(SEL_A, STORE_DEPTH - 1, 1'b0);
		push_word(SEL_A, 32'sh0001_0000, 1'b1);
		push_operand(SEL_B, STORE_DEPTH - 1, 1'b0);
		push_word(SEL_B, -32'sh0001_0000, 1'b1);

		while (pending_words.size() < TOTAL_WORDS) begin
			int unsigned r;
			int nb;
			int split;
			r = $urandom_range(0, 99);
			if (r < 70) begin
				push_operand(SEL_A, pick_length(), 1'b1);
				push_operand(SEL_B, pick_length(), 1'b1);
			end else if (r < 80) begin
				nb = pick_length();
				split = $urandom_range(0, nb - 1);
				push_operand(SEL_B, split, 1'b0);
				push_operand(SEL_A, pick_length(), 1'b1);
				push_operand(SEL_B, nb - split, 1'b1);
			end else if (r < 90) begin
				push_operand(SEL_A, pick_length(), 1'b1);
				repeat ($urandom_range(1, 3))
					push_word(SEL_A, rand_coef(), 1'($urandom_range(0, 1)));
				push_operand(SEL_B, pick_length(), 1'b1);
			end else if (r < 95) begin
				push_operand(SEL_B, pick_length(), 1'b1);
			end else begin
				// A never closed before the product fires
				push_operand(SEL_A, pick_length(), 1'b0);
				push_operand(SEL_B, pick_length(), 1'b1);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || coef_valid || expected_terms.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Sent %0d coefficient words, checked %0d product words over %0d products.",
			words_sent, results_seen, products);
		$display("Saturated products: %0d, with dropped words: %0d, highest degree: %0d.",
			saturated_products, dropped_products, top_degree);
		if (errors == 0 && expected_terms.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
